// ----- design/bitmap_glyph_pixel_expander_top_assert.svh -----
// ----------------------------------------------------------------------------
// Glyph pixel expander assertion macros
// Clocked, reset-gated implication checks shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_GLYPH_PIXEL_EXPANDER_TOP_ASSERT_SVH
`define BITMAP_GLYPH_PIXEL_EXPANDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph pixel expander package
// Shared types, widths, register codes and font size tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpe_pkg;

  localparam int unsigned GPE_COORD_BITS = 10;
  localparam int unsigned GPE_FIFO_DEPTH = 2;  // power of two, pointers wrap
  localparam int unsigned GPE_BYTE_BITS  = 8;

  localparam int unsigned GPE_XY_W    = 10;
  localparam int unsigned GPE_COLOR_W = 16;
  localparam int unsigned GPE_GH_W    = 6;
  localparam int unsigned GPE_LEN_W   = 7;
  localparam int unsigned GPE_CFG_W   = 16;

  localparam int unsigned GPE_IN_FIELDS_W  = 2 * GPE_XY_W + GPE_COLOR_W + 1 + GPE_BYTE_BITS;
  localparam int unsigned GPE_IN_DATA_W    = ((GPE_IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned GPE_OUT_FIELDS_W = 2 * GPE_XY_W + GPE_COLOR_W;
  localparam int unsigned GPE_OUT_DATA_W   = ((GPE_OUT_FIELDS_W + 7) / 8) * 8;

  // Font sizes and glyph byte counts: ceil(H/8) * (H/2)
  localparam logic [GPE_GH_W-1:0]  GPE_SIZE_12 = 6'd12;
  localparam logic [GPE_GH_W-1:0]  GPE_SIZE_16 = 6'd16;
  localparam logic [GPE_GH_W-1:0]  GPE_SIZE_24 = 6'd24;
  localparam logic [GPE_GH_W-1:0]  GPE_SIZE_32 = 6'd32;
  localparam logic [GPE_LEN_W-1:0] GPE_LEN_12  = 7'(((12 + 7) / 8) * (12 / 2));
  localparam logic [GPE_LEN_W-1:0] GPE_LEN_16  = 7'(((16 + 7) / 8) * (16 / 2));
  localparam logic [GPE_LEN_W-1:0] GPE_LEN_24  = 7'(((24 + 7) / 8) * (24 / 2));
  localparam logic [GPE_LEN_W-1:0] GPE_LEN_32  = 7'(((32 + 7) / 8) * (32 / 2));

  // Register reset values
  localparam logic [GPE_GH_W-1:0]    GPE_RST_GLYPH_HEIGHT  = GPE_SIZE_12;
  localparam logic [GPE_COLOR_W-1:0] GPE_RST_BACK_COLOR    = 16'hFFFF;
  localparam logic [GPE_XY_W-1:0]    GPE_RST_SCREEN_WIDTH  = 10'd320;
  localparam logic [GPE_XY_W-1:0]    GPE_RST_SCREEN_HEIGHT = 10'd240;

  typedef enum logic [1:0] {
    GPE_REG_GLYPH_HEIGHT,
    GPE_REG_BACK_COLOR,
    GPE_REG_SCREEN_WIDTH,
    GPE_REG_SCREEN_HEIGHT
  } gpe_reg_e;

  typedef enum logic {
    GPE_KIND_CONT,
    GPE_KIND_START
  } gpe_kind_e;

  typedef struct packed {
    gpe_kind_e                kind;
    logic [GPE_XY_W-1:0]      origin_x;
    logic [GPE_XY_W-1:0]      origin_y;
    logic [GPE_COLOR_W-1:0]   fg_color;
    logic                     overlay;
    logic [GPE_BYTE_BITS-1:0] font_byte;
  } gpe_item_t;

  typedef struct packed {
    logic [GPE_GH_W-1:0]    glyph_height;
    logic [GPE_COLOR_W-1:0] back_color;
    logic [GPE_XY_W-1:0]    screen_width;
    logic [GPE_XY_W-1:0]    screen_height;
  } gpe_cfg_t;

  // Column height; unsupported sizes act as 12
  function automatic logic [GPE_GH_W-1:0] gpe_col_height(input logic [GPE_GH_W-1:0] gh);
    logic [GPE_GH_W-1:0] h;
    case (gh)
      GPE_SIZE_16, GPE_SIZE_24, GPE_SIZE_32: h = gh;
      default:                               h = GPE_SIZE_12;
    endcase
    return h;
  endfunction

  function automatic logic [GPE_LEN_W-1:0] gpe_glyph_len(input logic [GPE_GH_W-1:0] gh);
    logic [GPE_LEN_W-1:0] len;
    case (gpe_col_height(gh))
      GPE_SIZE_16: len = GPE_LEN_16;
      GPE_SIZE_24: len = GPE_LEN_24;
      GPE_SIZE_32: len = GPE_LEN_32;
      default:     len = GPE_LEN_12;
    endcase
    return len;
  endfunction

endpackage

// ----- design/gpe_front.sv -----
// ----------------------------------------------------------------------------
// Glyph pixel expander front end
// Register incoming requests, unpack and tag them, and hand them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpe_front import gpe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [GPE_IN_DATA_W-1:0] s_tdata_i,
  input  logic                     s_tuser_i,
  output logic                     push_valid_o,
  output gpe_item_t                push_item_o,
  input  logic                     push_ready_i
);

  logic      valid_q, valid_d;
  gpe_item_t item_q, item_d;
  logic      take;

  assign s_tready_o = !valid_q || push_ready_i;
  assign take       = s_tvalid_i && s_tready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d            = 1'b1;
      item_d.kind        = s_tuser_i ? GPE_KIND_START : GPE_KIND_CONT;
      item_d.origin_x    = s_tdata_i[GPE_XY_W-1:0];
      item_d.origin_y    = s_tdata_i[2*GPE_XY_W-1:GPE_XY_W];
      item_d.fg_color    = s_tdata_i[2*GPE_XY_W+GPE_COLOR_W-1:2*GPE_XY_W];
      item_d.overlay     = s_tdata_i[2*GPE_XY_W+GPE_COLOR_W];
      item_d.font_byte   = s_tdata_i[GPE_IN_FIELDS_W-1:GPE_IN_FIELDS_W-GPE_BYTE_BITS];
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

// ----- design/gpe_fifo.sv -----
// ----------------------------------------------------------------------------
// Glyph pixel expander request queue
// Short queue that decouples the front end from the pixel engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpe_fifo import gpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  input  gpe_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output gpe_item_t pop_item_o,
  input  logic      pop_ready_i
);

  localparam int unsigned PTR_W = $clog2(GPE_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(GPE_FIFO_DEPTH + 1);

  gpe_item_t         mem_q [GPE_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != CNT_W'(GPE_FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/gpe_back.sv -----
// ----------------------------------------------------------------------------
// Glyph pixel expander pixel engine
// Walk font bytes one bit per cycle while output is free, track cursor, emit pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpe_back import gpe_pkg::*; #(
  parameter int unsigned COORD_BITS = GPE_COORD_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gpe_cfg_t               cfg_i,
  input  logic                   q_valid_i,
  input  gpe_item_t              q_item_i,
  output logic                   q_ready_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [GPE_XY_W-1:0]    pix_x_o,
  output logic [GPE_XY_W-1:0]    pix_y_o,
  output logic [GPE_COLOR_W-1:0] pix_color_o,
  output logic                   last_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned KW    = $clog2(GPE_BYTE_BITS);
  localparam int unsigned NW    = KW + 1;
  localparam int unsigned RW    = GPE_BYTE_BITS - 1;
  localparam logic [KW-1:0] K_LAST   = KW'(GPE_BYTE_BITS - 1);
  localparam logic [RW-1:0] REST_ONE = '1;

  // glyph state
  logic [CB-1:0]          cx_q, cx_d, cy_q, cy_d, top_q, top_d;
  logic [GPE_LEN_W-1:0]   cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [GPE_COLOR_W-1:0] color_q, color_d;
  logic                   ovl_q, ovl_d;
  // byte walk
  logic                     busy_q, busy_d;
  logic [KW-1:0]            k_q, k_d;
  logic [GPE_BYTE_BITS-1:0] bits_q, bits_d;
  // output register
  logic                   ov_q, ov_d;
  logic [GPE_XY_W-1:0]    ox_q, ox_d, oy_q, oy_d;
  logic [GPE_COLOR_W-1:0] oc_q, oc_d;
  logic                   ol_q, ol_d;

  // current view: registered byte, or the head of the queue with start applied
  logic                     load, is_start, have, out_free, drop, step;
  logic [CB-1:0]            e_cx, e_cy, e_top;
  logic [GPE_LEN_W-1:0]     e_cnt;
  logic                     e_done, e_ovl;
  logic [GPE_COLOR_W-1:0]   e_color;
  logic [GPE_BYTE_BITS-1:0] e_bits;
  logic [KW-1:0]            e_k;

  logic [GPE_GH_W-1:0]  h;
  logic [GPE_LEN_W-1:0] glen, cnt_inc;
  logic [CB-1:0]        h_c, cy_n, d_off, s_col;
  logic [CB:0]          ny, nx, sh_w, sw_w, cy_w, e_edge;
  logic                 hit_h, hit_w, col_end, term, cur, emit;
  logic [NW-1:0]        n0, n1, n2;
  logic [KW-1:0]        later;
  logic [RW-1:0]        later_mask;
  logic                 later_emit;

  assign load     = !busy_q && q_valid_i;
  assign is_start = load && (q_item_i.kind == GPE_KIND_START);
  assign have     = busy_q || q_valid_i;
  assign out_free = !ov_q || m_ready_i;

  always_comb begin
    e_cx    = is_start ? CB'(q_item_i.origin_x) : cx_q;
    e_cy    = is_start ? CB'(q_item_i.origin_y) : cy_q;
    e_top   = is_start ? CB'(q_item_i.origin_y) : top_q;
    e_color = is_start ? q_item_i.fg_color : color_q;
    e_ovl   = is_start ? q_item_i.overlay : ovl_q;
    e_cnt   = is_start ? '0 : cnt_q;
    e_done  = is_start ? 1'b0 : done_q;
    e_bits  = busy_q ? bits_q : q_item_i.font_byte;
    e_k     = busy_q ? k_q : '0;
  end

  assign drop      = load && e_done;
  assign step      = have && !e_done && out_free;
  assign q_ready_o = drop || (load && step);

  // one column step
  assign h       = gpe_col_height(cfg_i.glyph_height);
  assign glen    = gpe_glyph_len(cfg_i.glyph_height);
  assign h_c     = CB'(h);
  assign sh_w    = (CB+1)'(cfg_i.screen_height);
  assign sw_w    = (CB+1)'(cfg_i.screen_width);
  assign ny      = (CB+1)'(e_cy) + (CB+1)'(1);
  assign nx      = (CB+1)'(e_cx) + (CB+1)'(1);
  assign cy_n    = ny[CB-1:0];
  assign hit_h   = ny >= sh_w;
  assign hit_w   = nx >= sw_w;
  assign col_end = (cy_n - e_top) == h_c;
  assign term    = hit_h || col_end || (e_k == K_LAST);
  assign cur     = e_bits[GPE_BYTE_BITS-1];
  assign emit    = cur || !e_ovl;
  assign cnt_inc = e_cnt + 1'b1;

  // steps left in this byte, this one included: bit budget, column end, bottom edge
  assign d_off  = e_cy - e_top;
  assign s_col  = h_c - d_off;
  assign cy_w   = (CB+1)'(e_cy);
  assign e_edge = (cy_w >= sh_w) ? (CB+1)'(1) : sh_w - cy_w;

  always_comb begin
    n0 = NW'(GPE_BYTE_BITS) - NW'(e_k);
    n1 = ((s_col != '0) && (s_col < CB'(n0))) ? NW'(s_col) : n0;
    n2 = (e_edge < (CB+1)'(n1)) ? NW'(e_edge) : n1;
    later      = KW'(n2 - NW'(1));
    later_mask = ~(REST_ONE >> later);
    later_emit = ((later != '0) && !e_ovl) || (|(e_bits[RW-1:0] & later_mask));
  end

  always_comb begin
    cx_d    = cx_q;
    cy_d    = cy_q;
    top_d   = top_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    color_d = color_q;
    ovl_d   = ovl_q;
    busy_d  = busy_q;
    k_d     = k_q;
    bits_d  = bits_q;
    ov_d    = ov_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oc_d    = oc_q;
    ol_d    = ol_q;

    if (m_ready_i) begin
      ov_d = 1'b0;
    end

    if (step) begin
      top_d   = e_top;
      color_d = e_color;
      ovl_d   = e_ovl;
      cx_d    = e_cx;
      cnt_d   = e_cnt;
      done_d  = 1'b0;
      cy_d    = cy_n;
      busy_d  = !term;
      k_d     = e_k + 1'b1;
      bits_d  = e_bits << 1;

      if (hit_h) begin
        done_d = 1'b1;
      end else if (col_end) begin
        cy_d = e_top;
        cx_d = nx[CB-1:0];
        if (hit_w) begin
          done_d = 1'b1;
        end else begin
          cnt_d  = cnt_inc;
          done_d = cnt_inc >= glen;
        end
      end else if (term) begin
        cnt_d  = cnt_inc;
        done_d = cnt_inc >= glen;
      end

      if (emit) begin
        ov_d = 1'b1;
        ox_d = GPE_XY_W'(e_cx);
        oy_d = GPE_XY_W'(e_cy);
        oc_d = cur ? e_color : cfg_i.back_color;
        ol_d = !later_emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      top_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b1;
      color_q <= '0;
      ovl_q   <= 1'b0;
      busy_q  <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      color_q <= color_d;
      ovl_q   <= ovl_d;
      busy_q  <= busy_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
  end

  assign m_valid_o   = ov_q;
  assign pix_x_o     = ox_q;
  assign pix_y_o     = oy_q;
  assign pix_color_o = oc_q;
  assign last_o      = ol_q;

endmodule

// ----- design/bitmap_glyph_pixel_expander_top.sv -----
// ----------------------------------------------------------------------------
// Bitmap glyph pixel expander
// Turn column-major font bytes into a stream of pixel writes.
// ----------------------------------------------------------------------------
// Send a glyph's font bytes in order, with tuser high on the first one to latch
// origin, foreground color and overlay mode. Each byte is walked MSB first, one
// bit per cycle, down the current column: set bits write the foreground color,
// clear bits write back_color unless overlay is set. A byte covers as many column
// steps as it has bits, fewer when it closes a column or hits the bottom edge,
// and is dropped when no glyph is active. The single-step engine walks one bit
// per cycle while downstream keeps tready high and a byte is waiting; in overlay
// mode clear bits write no pixel. A request passes a front register, a two-entry
// queue and the engine's output register before its first pixel leaves, and new
// requests keep flowing in while the engine works, until the queue and front
// register fill. tlast marks the final pixel a byte causes. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_glyph_pixel_expander_top import gpe_pkg::*; #(
  parameter int unsigned COORD_BITS = GPE_COORD_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [GPE_CFG_W-1:0]      cfg_wdata_i,
  // font byte requests
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // origin_x[9:0], origin_y[19:10], fg_color[35:20], overlay[36], font_byte[44:37]
  input  logic [GPE_IN_DATA_W-1:0]  s_axis_tdata,
  // glyph_start[0]
  input  logic                      s_axis_tuser,
  // pixel writes
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // pix_x[9:0], pix_y[19:10], pix_color[35:20]
  output logic [GPE_OUT_DATA_W-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);

  gpe_cfg_t               cfg_q, cfg_d;
  logic                   push_valid, push_ready;
  gpe_item_t              push_item;
  logic                   pop_valid, pop_ready;
  gpe_item_t              pop_item;
  logic [GPE_XY_W-1:0]    pix_x, pix_y;
  logic [GPE_COLOR_W-1:0] pix_color;

  // Register file: truncate write data to the register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (gpe_reg_e'(cfg_idx_i))
        GPE_REG_GLYPH_HEIGHT:  cfg_d.glyph_height  = cfg_wdata_i[GPE_GH_W-1:0];
        GPE_REG_BACK_COLOR:    cfg_d.back_color    = cfg_wdata_i[GPE_COLOR_W-1:0];
        GPE_REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_wdata_i[GPE_XY_W-1:0];
        GPE_REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_wdata_i[GPE_XY_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_height  <= GPE_RST_GLYPH_HEIGHT;
      cfg_q.back_color    <= GPE_RST_BACK_COLOR;
      cfg_q.screen_width  <= GPE_RST_SCREEN_WIDTH;
      cfg_q.screen_height <= GPE_RST_SCREEN_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: take the request, tag start bytes
  gpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  // Queue between front end and pixel engine
  gpe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // Pixel engine: one bit per cycle into the output register while it is free
  gpe_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (pop_valid),
    .q_item_i    (pop_item),
    .q_ready_o   (pop_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .last_o      (m_axis_tlast)
  );

  // Pack pixel fields, pad to whole bytes
  assign m_axis_tdata = GPE_OUT_DATA_W'({pix_color, pix_y, pix_x});

endmodule

// ----- design/gpe_checker.sv -----
// ----------------------------------------------------------------------------
// Glyph pixel expander checker
// Port-level checks on the pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_glyph_pixel_expander_top_assert.svh"

module gpe_checker import gpe_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [GPE_OUT_DATA_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);

  localparam int unsigned PW = $clog2(GPE_BYTE_BITS);
  localparam logic [PW-1:0] PIX_MAX = PW'(GPE_BYTE_BITS - 1);

  logic                out_fire;
  logic [PW-1:0]       pix_cnt_q, pix_cnt_d;
  logic                in_byte_q, in_byte_d;
  logic [GPE_XY_W-1:0] col_q, col_d;

  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Track pixels of the current byte
  always_comb begin
    pix_cnt_d = pix_cnt_q;
    in_byte_d = in_byte_q;
    col_d     = col_q;
    if (out_fire) begin
      pix_cnt_d = m_axis_tlast ? '0 : pix_cnt_q + 1'b1;
      in_byte_d = !m_axis_tlast;
      col_d     = m_axis_tdata[GPE_XY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q <= '0;
      in_byte_q <= 1'b0;
      col_q     <= '0;
    end else begin
      pix_cnt_q <= pix_cnt_d;
      in_byte_q <= in_byte_d;
      col_q     <= col_d;
    end
  end

  `GPE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "pixel changed while stalled")
  `GPE_ASSERT_NOW(a_eight_max, out_fire && (pix_cnt_q == PIX_MAX), m_axis_tlast, "more than eight pixels from one byte")
  `GPE_ASSERT_NOW(a_one_column, out_fire && in_byte_q, m_axis_tdata[GPE_XY_W-1:0] == col_q, "byte left its column")

endmodule

bind bitmap_glyph_pixel_expander_top gpe_checker u_gpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
